[rtl/ffa_pkg.sv]
// Shared constants, codes and field widths for the first-fit heap allocator.
package ffa_pkg;

  // Default sizing of the managed heap.
  localparam int DEF_HEAP_GRANULES   = 4096;
  localparam int DEF_GRANULE_BYTES   = 8;
  localparam int DEF_MIN_BLOCK_BYTES = 16;

  // Every block starts with a header of this many bytes.
  localparam int HDR_BYTES = 16;

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int REQ_W    = 16;
  localparam int ADDR_W   = 32;
  localparam int STAT_W   = 2;
  localparam int USED_W   = 16;
  localparam int HBYTES_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;
  // Dividend width of the granule divider (header plus request plus rounding).
  localparam int DIV_W    = 17;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM    = 2'd1;
  localparam logic [STAT_W-1:0] ST_DOUBLE = 2'd2;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 1'd1;

endpackage

[rtl/ffa_table.sv]
// Block table memory: one write port and one read port with registered data.
module ffa_table import ffa_pkg::*; #(
  parameter int DEPTH = DEF_HEAP_GRANULES,
  parameter int WIDTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/first_fit_heap_allocator_top.sv]
// First-fit heap allocator: a sequencer walks an address-ordered block table held in a
// single-port-read memory, reading and then checking one block at a time. Init divides the
// heap size into granules and runs a clearing sweep over all HEAP_GRANULES entries; the same
// clearing sweep runs after reset, during which no transfer is accepted. Allocate divides
// the request into granules and walks the blocks up to the first fit. Release walks the
// blocks from the heap start up to and including the released block, then merges it with
// free neighbours. One command is worked on at a time; a finished result waits in the
// output register while the next command is taken.
module first_fit_heap_allocator_top import ffa_pkg::*; #(
  parameter int HEAP_GRANULES   = DEF_HEAP_GRANULES,
  parameter int GRANULE_BYTES   = DEF_GRANULE_BYTES,
  parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  // Command stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          in_tdata,  // request_bytes[15:0], block_address[47:16]
  input  logic [1:0]           in_tuser,  // command[1:0]
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata, // payload_address[31:0], used_bytes[47:32]
  output logic [1:0]           out_tuser  // status[1:0]
);

  localparam int AW      = $clog2(HEAP_GRANULES);
  localparam int SW      = $clog2(HEAP_GRANULES + 1);
  localparam int EW      = SW + 2;
  localparam int GW      = AW + 2;
  localparam int MIN_G   = (MIN_BLOCK_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int SPLIT_G = MIN_BLOCK_BYTES / GRANULE_BYTES;
  // Reciprocal of the granule size, exact for every dividend of DIV_W bits.
  localparam int RCP_SH  = DIV_W + $clog2(GRANULE_BYTES);
  localparam int RCP_M   = ((1 << RCP_SH) + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int PW      = DIV_W + RCP_SH;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_INIT_FIN, S_A_RD, S_A_CHK, S_A_MARK,
    S_R_RD, S_R_CHK, S_R_NRD, S_R_NCHK, S_R_WG, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [HBYTES_W-1:0] hbytes_r, hbytes_nxt;
  logic               ready_r, ready_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic               init_pend_r, init_pend_nxt;
  logic [AW:0]        clr_r, clr_nxt;
  logic [DIV_W-1:0]   dvd_r, dvd_nxt;
  logic [DIV_W-1:0]   need_r, need_nxt;
  logic [GW-1:0]      p_r, p_nxt;
  logic [ADDR_W-1:0]  pb_r, pb_nxt;
  logic [ADDR_W-1:0]  off_r, off_nxt;
  logic [SW-1:0]      sz_r, sz_nxt;
  logic [GW-1:0]      nx_r, nx_nxt;
  logic [AW-1:0]      prev_r, prev_nxt;
  logic [EW-1:0]      prev_ent_r, prev_ent_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [STAT_W-1:0]  st_r, st_nxt;
  logic [ADDR_W-1:0]  pa_r, pa_nxt;
  logic               ov_r, ov_nxt;
  logic [STAT_W-1:0]  ost_r, ost_nxt;
  logic [ADDR_W-1:0]  opa_r, opa_nxt;
  logic [USED_W-1:0]  oused_r, oused_nxt;

  // Memory port signals.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  ffa_table #(.DEPTH(HEAP_GRANULES), .WIDTH(EW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Fields of the entry just read.
  logic          ent_valid, ent_free;
  logic [SW-1:0] ent_size;
  assign ent_valid = mem_rdata[0];
  assign ent_free  = mem_rdata[1];
  assign ent_size  = mem_rdata[EW-1:2];

  // Division by the granule size through multiplication with its reciprocal.
  logic [PW-1:0]    q_prod;
  logic [DIV_W-1:0] q_val;
  assign q_prod = PW'(dvd_r) * PW'(RCP_M);
  assign q_val  = q_prod[PW-1:RCP_SH];

  logic [DIV_W-1:0] a_diff;
  logic [ADDR_W-1:0] blk_bytes;
  assign a_diff    = DIV_W'(ent_size) - need_r;
  assign blk_bytes = ADDR_W'(ent_size) * ADDR_W'(GRANULE_BYTES);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {oused_r, opa_r};
  assign out_tuser  = ost_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    hbytes_nxt    = hbytes_r;
    ready_nxt     = ready_r;
    used_nxt      = used_r;
    cmd_nxt       = cmd_r;
    init_pend_nxt = init_pend_r;
    clr_nxt       = clr_r;
    dvd_nxt       = dvd_r;
    need_nxt      = need_r;
    p_nxt         = p_r;
    pb_nxt        = pb_r;
    off_nxt       = off_r;
    sz_nxt        = sz_r;
    nx_nxt        = nx_r;
    prev_nxt      = prev_r;
    prev_ent_nxt  = prev_ent_r;
    have_prev_nxt = have_prev_r;
    st_nxt        = st_r;
    pa_nxt        = pa_r;
    ov_nxt        = ov_r;
    ost_nxt       = ost_r;
    opa_nxt       = opa_r;
    oused_nxt     = oused_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = p_r[AW-1:0];

    if (cfg_we) begin
      case (cfg_addr)
        REG_HEAP_BASE:  base_nxt = cfg_wdata;
        REG_HEAP_BYTES: hbytes_nxt = cfg_wdata[HBYTES_W-1:0];
        default: ;
      endcase
    end

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      // Clearing sweep over the whole table.
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[AW-1:0];
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == (AW+1)'(HEAP_GRANULES - 1)) begin
          state_nxt = init_pend_r ? S_INIT_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt       = in_tuser;
          pa_nxt        = '0;
          st_nxt        = ST_REJECT;
          p_nxt         = '0;
          pb_nxt        = '0;
          have_prev_nxt = 1'b0;
          off_nxt       = in_tdata[47:16] - base_r - ADDR_W'(HDR_BYTES);
          case (in_tuser)
            CMD_INIT: begin
              dvd_nxt   = DIV_W'(hbytes_r);
              state_nxt = S_DIV;
            end
            CMD_ALLOC: begin
              dvd_nxt   = DIV_W'(in_tdata[15:0]) + DIV_W'(HDR_BYTES + GRANULE_BYTES - 1);
              state_nxt = (in_tdata[15:0] == '0 || !ready_r) ? S_DONE : S_DIV;
            end
            CMD_RELEASE: begin
              state_nxt = (in_tdata[47:16] == '0 || !ready_r) ? S_DONE : S_R_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // Granule count of the dividend.
      S_DIV: begin
        dvd_nxt = q_val;
        if (cmd_r == CMD_INIT) begin
          init_pend_nxt = 1'b1;
          clr_nxt       = '0;
          state_nxt     = S_CLEAR;
        end else begin
          if (q_val < DIV_W'(MIN_G)) begin
            need_nxt = DIV_W'(MIN_G);
          end else begin
            need_nxt = q_val;
          end
          state_nxt = S_A_RD;
        end
      end
      S_INIT_FIN: begin
        init_pend_nxt = 1'b0;
        used_nxt      = '0;
        if (base_r == '0) begin
          ready_nxt = 1'b0;
          st_nxt    = ST_REJECT;
        end else begin
          ready_nxt = 1'b1;
          st_nxt    = ST_OK;
          if (dvd_r != '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            if (dvd_r > DIV_W'(HEAP_GRANULES)) begin
              mem_wdata = {SW'(HEAP_GRANULES), 2'b11};
            end else begin
              mem_wdata = {dvd_r[SW-1:0], 2'b11};
            end
          end
        end
        state_nxt = S_DONE;
      end
      // First-fit walk.
      S_A_RD: begin
        if (p_r >= GW'(HEAP_GRANULES)) begin
          st_nxt    = ST_OOM;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (!ent_valid || ent_size == '0) begin
          st_nxt    = ST_OOM;
          state_nxt = S_DONE;
        end else if (ent_free && DIV_W'(ent_size) >= need_r) begin
          if (a_diff > DIV_W'(SPLIT_G)) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(p_r + GW'(need_r));
            mem_wdata = {a_diff[SW-1:0], 2'b11};
            sz_nxt    = need_r[SW-1:0];
          end else begin
            sz_nxt = ent_size;
          end
          state_nxt = S_A_MARK;
        end else begin
          p_nxt     = p_r + GW'(ent_size);
          state_nxt = S_A_RD;
        end
      end
      S_A_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = p_r[AW-1:0];
        mem_wdata = {sz_r, 2'b01};
        used_nxt  = used_r + USED_W'(ADDR_W'(sz_r) * ADDR_W'(GRANULE_BYTES));
        pa_nxt    = base_r + ADDR_W'(p_r) * ADDR_W'(GRANULE_BYTES) + ADDR_W'(HDR_BYTES);
        st_nxt    = ST_OK;
        state_nxt = S_DONE;
      end
      // Chain walk up to the released block.
      S_R_RD: begin
        if (p_r >= GW'(HEAP_GRANULES)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_R_CHK;
        end
      end
      S_R_CHK: begin
        if (pb_r == off_r) begin
          if (!ent_valid) begin
            state_nxt = S_DONE;
          end else if (ent_free) begin
            st_nxt    = ST_DOUBLE;
            state_nxt = S_DONE;
          end else begin
            sz_nxt    = ent_size;
            nx_nxt    = p_r + GW'(ent_size);
            used_nxt  = (ADDR_W'(used_r) >= blk_bytes) ?
                        used_r - USED_W'(blk_bytes) : '0;
            state_nxt = S_R_NRD;
          end
        end else if (!ent_valid || ent_size == '0 || pb_r > off_r) begin
          state_nxt = S_DONE;
        end else begin
          prev_nxt      = p_r[AW-1:0];
          prev_ent_nxt  = mem_rdata;
          have_prev_nxt = 1'b1;
          p_nxt         = p_r + GW'(ent_size);
          pb_nxt        = pb_r + blk_bytes;
          state_nxt     = S_R_RD;
        end
      end
      S_R_NRD: begin
        mem_raddr = nx_r[AW-1:0];
        state_nxt = (nx_r < GW'(HEAP_GRANULES)) ? S_R_NCHK : S_R_WG;
      end
      // Merge with a free next block.
      S_R_NCHK: begin
        if (ent_valid && ent_free) begin
          sz_nxt    = sz_r + ent_size;
          mem_we    = 1'b1;
          mem_waddr = nx_r[AW-1:0];
          mem_wdata = '0;
        end
        state_nxt = S_R_WG;
      end
      // Merge into a free previous block, or mark this one free.
      S_R_WG: begin
        st_nxt = ST_OK;
        if (have_prev_r && prev_ent_r[1]) begin
          mem_we    = 1'b1;
          mem_waddr = prev_r;
          mem_wdata = {prev_ent_r[EW-1:2] + sz_r, 2'b11};
          nx_nxt    = p_r;
          // The released header is then cleared on the way out.
          state_nxt = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = p_r[AW-1:0];
          mem_wdata = {sz_r, 2'b11};
          state_nxt = S_DONE;
        end
      end
      // Clear the released header after a merge into the previous block, and load the output register once it is free.
      S_DONE: begin
        if (have_prev_r && prev_ent_r[1] && cmd_r == CMD_RELEASE && st_r == ST_OK) begin
          mem_we    = 1'b1;
          mem_waddr = nx_r[AW-1:0];
          mem_wdata = '0;
        end
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          ost_nxt   = st_r;
          opa_nxt   = pa_r;
          oused_nxt = used_nxt;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      base_r      <= '0;
      hbytes_r    <= '0;
      ready_r     <= 1'b0;
      used_r      <= '0;
      init_pend_r <= 1'b0;
      clr_r       <= '0;
      ov_r        <= 1'b0;
      have_prev_r <= 1'b0;
      st_r        <= ST_REJECT;
      cmd_r       <= CMD_INIT;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      hbytes_r    <= hbytes_nxt;
      ready_r     <= ready_nxt;
      used_r      <= used_nxt;
      init_pend_r <= init_pend_nxt;
      clr_r       <= clr_nxt;
      ov_r        <= ov_nxt;
      have_prev_r <= have_prev_nxt;
      st_r        <= st_nxt;
      cmd_r       <= cmd_nxt;
    end
    dvd_r      <= dvd_nxt;
    need_r     <= need_nxt;
    p_r        <= p_nxt;
    pb_r       <= pb_nxt;
    off_r      <= off_nxt;
    sz_r       <= sz_nxt;
    nx_r       <= nx_nxt;
    prev_r     <= prev_nxt;
    prev_ent_r <= prev_ent_nxt;
    pa_r       <= pa_nxt;
    ost_r      <= ost_nxt;
    opa_r      <= opa_nxt;
    oused_r    <= oused_nxt;
  end

endmodule
